>>> rtl/core/sscd_pkg.sv
`default_nettype none

package sscd_pkg;

    // Field and datapath widths.
    localparam int COORD_W    = 32;   // input coordinate, signed fixed point
    localparam int NUM_COORD  = 12;   // p1, p2, q1, q2, three axes each
    localparam int NUM_VEC    = 9;    // u, v, w, three axes each
    localparam int VEC_W      = 33;   // exact difference of two coordinates
    localparam int MAG_W      = 32;   // magnitude of a difference
    localparam int LEN_W      = 6;    // bit length of a magnitude, 0 to 32
    localparam int SHIFT_W    = 5;    // common scaling shift
    localparam int LIM_FIRST  = 14;   // magnitude bound for the first solve
    localparam int LIM_REST   = 20;   // magnitude bound for the later solves
    localparam int SC1_W      = LIM_FIRST + 1;
    localparam int SC2_W      = LIM_REST + 1;
    localparam int DOT1_W     = 2 * LIM_FIRST + 3;
    localparam int DOT2_W     = 2 * LIM_REST + 3;
    localparam int N1_W       = 2 * DOT1_W + 1;
    localparam int QW         = 16;   // quotient bits of a clamped parameter
    localparam int PARAM_W    = QW + 1;
    localparam int TN_W       = DOT2_W + PARAM_W;
    localparam int DD_W       = VEC_W + PARAM_W + 2;
    localparam int SUM_W      = 2 * QW + 2;
    localparam int DIST_W     = 32;
    localparam int COORD_FRAC_BITS = 16;

    localparam logic [PARAM_W-1:0] PARAM_ONE = PARAM_W'(1) << QW;

    localparam int FIFO_DEPTH_DEFAULT = 4;

    // Request handed from the front part to the back part.
    typedef struct packed {
        logic [NUM_VEC-1:0][VEC_W-1:0] vec;
        logic [DOT2_W-1:0]             a;
        logic [DOT2_W-1:0]             b;
        logic [DOT2_W-1:0]             c;
        logic [DOT2_W-1:0]             d;
        logic [DOT2_W-1:0]             e;
        logic [N1_W-1:0]               den;
        logic [N1_W-1:0]               num;
    } t_fq;

endpackage

`default_nettype wire

>>> rtl/core/sscd_div.sv
`default_nettype none

module sscd_div import sscd_pkg::*; #(
    parameter int W  = N1_W - 1,
    parameter int PW = 1
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic signed [W:0]    i_num,
    input  logic signed [W:0]    i_den,
    input  logic [PW-1:0]        i_pay,
    output logic                 o_valid,
    output logic [PARAM_W-1:0]   o_quo,
    output logic [PW-1:0]        o_pay
);

    logic [QW:0]     r_vld;
    logic [QW:0]     r_zero;
    logic [QW:0]     r_one;
    logic [W-1:0]    r_rem [0:QW];
    logic [W-1:0]    r_dvs [0:QW];
    logic [QW-1:0]   r_quo [0:QW];
    logic [PW-1:0]   r_pay [0:QW];

    logic [W:0]      n_sh  [1:QW];
    logic [QW:1]     n_ge;
    logic [W-1:0]    n_rem [1:QW];
    logic [QW-1:0]   n_quo [1:QW];
    logic            w_zero;
    logic            w_one;

    assign w_zero = (i_den <= 0) || (i_num <= 0);
    assign w_one  = i_num >= i_den;

    // One restoring step per stage.
    always_comb begin
        for (int k = 1; k <= QW; k++) begin
            n_sh[k]  = {r_rem[k-1], 1'b0};
            n_ge[k]  = n_sh[k] >= {1'b0, r_dvs[k-1]};
            n_rem[k] = n_ge[k] ? W'(n_sh[k] - {1'b0, r_dvs[k-1]}) : n_sh[k][W-1:0];
            n_quo[k] = {r_quo[k-1][QW-2:0], n_ge[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[QW-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zero   <= {r_zero[QW-1:0], w_zero};
            r_one    <= {r_one[QW-1:0], !w_zero && w_one};
            r_rem[0] <= i_num[W-1:0];
            r_dvs[0] <= i_den[W-1:0];
            r_quo[0] <= '0;
            r_pay[0] <= i_pay;
            for (int k = 1; k <= QW; k++) begin
                r_rem[k] <= n_rem[k];
                r_dvs[k] <= r_dvs[k-1];
                r_quo[k] <= n_quo[k];
                r_pay[k] <= r_pay[k-1];
            end
        end
    end

    assign o_valid = r_vld[QW];
    assign o_pay   = r_pay[QW];
    assign o_quo   = r_zero[QW] ? '0 :
                     r_one[QW]  ? PARAM_ONE : {1'b0, r_quo[QW]};

endmodule

`default_nettype wire

>>> rtl/core/sscd_front.sv
`default_nettype none

module sscd_front import sscd_pkg::*; (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [NUM_COORD-1:0][COORD_W-1:0]  i_coord,
    output logic                               o_push,
    input  logic                               i_full,
    output t_fq                                o_data
);

    function automatic logic signed [DOT1_W-1:0] dot1(
        input logic signed [SC1_W-1:0] x0, x1, x2, y0, y1, y2
    );
        return x0 * y0 + x1 * y1 + x2 * y2;
    endfunction

    function automatic logic signed [DOT2_W-1:0] dot2(
        input logic signed [SC2_W-1:0] x0, x1, x2, y0, y1, y2
    );
        return x0 * y0 + x1 * y1 + x2 * y2;
    endfunction

    logic [4:0] r_v;
    logic       w_en;

    logic [NUM_VEC-1:0][VEC_W-1:0]  r1_vec, n1_vec;
    logic [NUM_VEC-1:0][VEC_W-1:0]  r2_vec;
    logic [NUM_VEC-1:0][MAG_W-1:0]  r2_mag, n2_mag;
    logic [NUM_VEC-1:0]             r2_neg, n2_neg;
    logic [SHIFT_W-1:0]             r2_k1, r2_k2, n2_k1, n2_k2;
    logic [MAG_W-1:0]               w_or;
    logic [LEN_W-1:0]               w_len;
    logic [NUM_VEC-1:0][VEC_W-1:0]  r3_vec;
    logic [NUM_VEC-1:0][SC1_W-1:0]  r3_s1, n3_s1;
    logic [NUM_VEC-1:0][SC2_W-1:0]  r3_s2, n3_s2;
    logic [NUM_VEC-1:0][VEC_W-1:0]  r4_vec;
    logic [4:0][DOT1_W-1:0]         r4_d1, n4_d1;
    logic [4:0][DOT2_W-1:0]         r4_d2, n4_d2;
    logic signed [DOT1_W-1:0]       w_a1, w_b1, w_c1, w_d1, w_e1;
    t_fq                            r5, n5;

    assign w_en    = !r_v[4] || !i_full;
    assign o_ready = w_en;
    assign o_push  = r_v[4] && !i_full;
    assign o_data  = r5;

    // Stage 1: u = P2 - P1, v = Q2 - Q1, w = P1 - Q1.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n1_vec[i]     = VEC_W'($signed(i_coord[3+i])) - VEC_W'($signed(i_coord[i]));
            n1_vec[3+i]   = VEC_W'($signed(i_coord[9+i])) - VEC_W'($signed(i_coord[6+i]));
            n1_vec[6+i]   = VEC_W'($signed(i_coord[i]))   - VEC_W'($signed(i_coord[6+i]));
        end
    end

    // Stage 2: magnitudes and the two common shifts from the largest bit length.
    always_comb begin
        w_or = '0;
        for (int i = 0; i < NUM_VEC; i++) begin
            n2_neg[i] = r1_vec[i][VEC_W-1];
            n2_mag[i] = n2_neg[i] ? MAG_W'(-r1_vec[i]) : r1_vec[i][MAG_W-1:0];
            w_or      = w_or | n2_mag[i];
        end
        w_len = '0;
        for (int j = 0; j < MAG_W; j++) begin
            if (w_or[j]) begin
                w_len = LEN_W'(j + 1);
            end
        end
        n2_k1 = (w_len > LEN_W'(LIM_FIRST)) ? SHIFT_W'(w_len - LEN_W'(LIM_FIRST)) : '0;
        n2_k2 = (w_len > LEN_W'(LIM_REST))  ? SHIFT_W'(w_len - LEN_W'(LIM_REST))  : '0;
    end

    // Stage 3: scale the magnitudes down and restore the signs.
    always_comb begin
        for (int i = 0; i < NUM_VEC; i++) begin
            n3_s1[i] = {1'b0, LIM_FIRST'(r2_mag[i] >> r2_k1)};
            n3_s2[i] = {1'b0, LIM_REST'(r2_mag[i] >> r2_k2)};
            if (r2_neg[i]) begin
                n3_s1[i] = -n3_s1[i];
                n3_s2[i] = -n3_s2[i];
            end
        end
    end

    // Stage 4: dot products a, b, c, d, e for both scalings.
    always_comb begin
        n4_d1[0] = dot1(r3_s1[0], r3_s1[1], r3_s1[2], r3_s1[0], r3_s1[1], r3_s1[2]);
        n4_d1[1] = dot1(r3_s1[0], r3_s1[1], r3_s1[2], r3_s1[3], r3_s1[4], r3_s1[5]);
        n4_d1[2] = dot1(r3_s1[3], r3_s1[4], r3_s1[5], r3_s1[3], r3_s1[4], r3_s1[5]);
        n4_d1[3] = dot1(r3_s1[0], r3_s1[1], r3_s1[2], r3_s1[6], r3_s1[7], r3_s1[8]);
        n4_d1[4] = dot1(r3_s1[3], r3_s1[4], r3_s1[5], r3_s1[6], r3_s1[7], r3_s1[8]);
        n4_d2[0] = dot2(r3_s2[0], r3_s2[1], r3_s2[2], r3_s2[0], r3_s2[1], r3_s2[2]);
        n4_d2[1] = dot2(r3_s2[0], r3_s2[1], r3_s2[2], r3_s2[3], r3_s2[4], r3_s2[5]);
        n4_d2[2] = dot2(r3_s2[3], r3_s2[4], r3_s2[5], r3_s2[3], r3_s2[4], r3_s2[5]);
        n4_d2[3] = dot2(r3_s2[0], r3_s2[1], r3_s2[2], r3_s2[6], r3_s2[7], r3_s2[8]);
        n4_d2[4] = dot2(r3_s2[3], r3_s2[4], r3_s2[5], r3_s2[6], r3_s2[7], r3_s2[8]);
    end

    // Stage 5: denominator and numerator of the first solve.
    always_comb begin
        w_a1 = r4_d1[0];
        w_b1 = r4_d1[1];
        w_c1 = r4_d1[2];
        w_d1 = r4_d1[3];
        w_e1 = r4_d1[4];
        n5.vec = r4_vec;
        n5.a   = r4_d2[0];
        n5.b   = r4_d2[1];
        n5.c   = r4_d2[2];
        n5.d   = r4_d2[3];
        n5.e   = r4_d2[4];
        n5.den = w_a1 * w_c1 - w_b1 * w_b1;
        n5.num = w_b1 * w_e1 - w_c1 * w_d1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_en) begin
            r_v <= {r_v[3:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_vec <= n1_vec;
            r2_vec <= r1_vec;
            r2_mag <= n2_mag;
            r2_neg <= n2_neg;
            r2_k1  <= n2_k1;
            r2_k2  <= n2_k2;
            r3_vec <= r2_vec;
            r3_s1  <= n3_s1;
            r3_s2  <= n3_s2;
            r4_vec <= r3_vec;
            r4_d1  <= n4_d1;
            r4_d2  <= n4_d2;
            r5     <= n5;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/sscd_fifo.sv
`default_nettype none

module sscd_fifo import sscd_pkg::*; #(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEFAULT
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_fq   i_data,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_fq   o_data
);

    localparam int AW = $clog2(FIFO_DEPTH);
    localparam int CW = $clog2(FIFO_DEPTH + 1);

    t_fq            r_mem [0:FIFO_DEPTH-1];
    logic [AW-1:0]  r_wr;
    logic [AW-1:0]  r_rd;
    logic [CW-1:0]  r_cnt;

    assign o_full  = r_cnt == CW'(FIFO_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AW'(FIFO_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == AW'(FIFO_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/sscd_back.sv
`default_nettype none

module sscd_back import sscd_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  t_fq                 i_data,
    output logic                o_pop,
    input  logic [DIST_W-1:0]   i_thresh,
    output logic                o_valid,
    input  logic                i_ready,
    output logic                o_contact,
    output logic [PARAM_W-1:0]  o_s,
    output logic [PARAM_W-1:0]  o_t,
    output logic [DIST_W-1:0]   o_dist
);

    typedef struct packed {
        logic [NUM_VEC-1:0][VEC_W-1:0] vec;
        logic [DOT2_W-1:0]             a;
        logic [DOT2_W-1:0]             b;
        logic [DOT2_W-1:0]             c;
        logic [DOT2_W-1:0]             d;
        logic [DOT2_W-1:0]             e;
    } t_p0;

    typedef struct packed {
        logic [NUM_VEC-1:0][VEC_W-1:0] vec;
        logic [DOT2_W-1:0]             a;
        logic [DOT2_W-1:0]             b;
        logic [DOT2_W-1:0]             d;
    } t_p1;

    typedef struct packed {
        logic [NUM_VEC-1:0][VEC_W-1:0] vec;
        logic [PARAM_W-1:0]            t;
    } t_p2;

    localparam logic [DD_W-1:0] ROUND_HALF = DD_W'(1) << (COORD_FRAC_BITS - 1);

    logic w_en;

    t_p0                   w_p0_in, w_p0_out;
    logic                  w_v0;
    logic [PARAM_W-1:0]    w_s0;

    logic                  r_v2;
    logic signed [TN_W-1:0] r2_tnum, r2_tden, n2_tnum, n2_tden;
    t_p1                   r2_pay, n2_pay;
    logic signed [DOT2_W-1:0] w_b0, w_c0, w_e0;
    logic signed [PARAM_W:0]  w_s0e;

    t_p1                   w_p1_out;
    logic                  w_v1;
    logic [PARAM_W-1:0]    w_t;

    logic                  r_v4;
    logic signed [TN_W-1:0] r4_snum, r4_sden, n4_snum, n4_sden;
    t_p2                   r4_pay, n4_pay;
    logic signed [DOT2_W-1:0] w_a1, w_b1, w_d1;
    logic signed [PARAM_W:0]  w_te;

    t_p2                   w_p2_out;
    logic                  w_v2;
    logic [PARAM_W-1:0]    w_s;
    logic signed [PARAM_W:0]  w_se2, w_te2;

    logic                  r_v6;
    logic signed [DD_W-1:0] r6_dd [0:2];
    logic signed [DD_W-1:0] n6_dd [0:2];
    logic [PARAM_W-1:0]    r6_s, r6_t;

    logic                  r_v7;
    logic [DD_W-1:0]       w_mag [0:2];
    logic [DD_W-1:0]       w_rnd [0:2];
    logic [2:0][QW-1:0]    r7_q, n7_q;
    logic                  r7_sat, n7_sat;
    logic [PARAM_W-1:0]    r7_s, r7_t;

    logic [SUM_W-1:0]      w_sum;
    logic [DIST_W-1:0]     n_dist;

    logic                  r_o_valid;
    logic                  r_o_contact;
    logic [PARAM_W-1:0]    r_o_s, r_o_t;
    logic [DIST_W-1:0]     r_o_dist;

    assign w_en  = !r_o_valid || i_ready;
    assign o_pop = w_en && i_valid;

    always_comb begin
        w_p0_in.vec = i_data.vec;
        w_p0_in.a   = i_data.a;
        w_p0_in.b   = i_data.b;
        w_p0_in.c   = i_data.c;
        w_p0_in.d   = i_data.d;
        w_p0_in.e   = i_data.e;
    end

    sscd_div #(
        .W  (N1_W - 1),
        .PW ($bits(t_p0))
    ) u_div_s0 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_num   (i_data.num),
        .i_den   (i_data.den),
        .i_pay   (w_p0_in),
        .o_valid (w_v0),
        .o_quo   (w_s0),
        .o_pay   (w_p0_out)
    );

    // t numerator b*s0 + e and denominator c, both in units of 2^-16.
    always_comb begin
        w_b0    = w_p0_out.b;
        w_c0    = w_p0_out.c;
        w_e0    = w_p0_out.e;
        w_s0e   = {1'b0, w_s0};
        n2_tnum = w_b0 * w_s0e + (w_e0 <<< QW);
        n2_tden = w_c0 <<< QW;
        n2_pay.vec = w_p0_out.vec;
        n2_pay.a   = w_p0_out.a;
        n2_pay.b   = w_p0_out.b;
        n2_pay.d   = w_p0_out.d;
    end

    sscd_div #(
        .W  (TN_W - 1),
        .PW ($bits(t_p1))
    ) u_div_t (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_v2),
        .i_num   (r2_tnum),
        .i_den   (r2_tden),
        .i_pay   (r2_pay),
        .o_valid (w_v1),
        .o_quo   (w_t),
        .o_pay   (w_p1_out)
    );

    // s numerator b*t - d and denominator a.
    always_comb begin
        w_a1    = w_p1_out.a;
        w_b1    = w_p1_out.b;
        w_d1    = w_p1_out.d;
        w_te    = {1'b0, w_t};
        n4_snum = w_b1 * w_te - (w_d1 <<< QW);
        n4_sden = w_a1 <<< QW;
        n4_pay.vec = w_p1_out.vec;
        n4_pay.t   = w_t;
    end

    sscd_div #(
        .W  (TN_W - 1),
        .PW ($bits(t_p2))
    ) u_div_s (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_v4),
        .i_num   (r4_snum),
        .i_den   (r4_sden),
        .i_pay   (r4_pay),
        .o_valid (w_v2),
        .o_quo   (w_s),
        .o_pay   (w_p2_out)
    );

    // Difference between the closest points: w + u*s - v*t, exact.
    always_comb begin
        w_se2 = {1'b0, w_s};
        w_te2 = {1'b0, w_p2_out.t};
        for (int i = 0; i < 3; i++) begin
            n6_dd[i] = ($signed(w_p2_out.vec[6+i]) <<< QW)
                     + $signed(w_p2_out.vec[i]) * w_se2
                     - $signed(w_p2_out.vec[3+i]) * w_te2;
        end
    end

    // Round each component to 2^-16 units, flag the far-apart case.
    always_comb begin
        n7_sat = 1'b0;
        for (int i = 0; i < 3; i++) begin
            w_mag[i] = r6_dd[i][DD_W-1] ? DD_W'(-r6_dd[i]) : DD_W'(r6_dd[i]);
            w_rnd[i] = w_mag[i] + ROUND_HALF;
            n7_q[i]  = w_rnd[i][COORD_FRAC_BITS +: QW];
            n7_sat   = n7_sat || (|w_rnd[i][DD_W-1:COORD_FRAC_BITS+QW]);
        end
    end

    always_comb begin
        w_sum  = SUM_W'(r7_q[0] * r7_q[0]) + SUM_W'(r7_q[1] * r7_q[1])
               + SUM_W'(r7_q[2] * r7_q[2]);
        n_dist = (r7_sat || (|w_sum[SUM_W-1:DIST_W])) ? '1 : w_sum[DIST_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2      <= 1'b0;
            r_v4      <= 1'b0;
            r_v6      <= 1'b0;
            r_v7      <= 1'b0;
            r_o_valid <= 1'b0;
        end else if (w_en) begin
            r_v2      <= w_v0;
            r_v4      <= w_v1;
            r_v6      <= w_v2;
            r_v7      <= r_v6;
            r_o_valid <= r_v7;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_tnum     <= n2_tnum;
            r2_tden     <= n2_tden;
            r2_pay      <= n2_pay;
            r4_snum     <= n4_snum;
            r4_sden     <= n4_sden;
            r4_pay      <= n4_pay;
            r6_dd       <= n6_dd;
            r6_s        <= w_s;
            r6_t        <= w_p2_out.t;
            r7_q        <= n7_q;
            r7_sat      <= n7_sat;
            r7_s        <= r6_s;
            r7_t        <= r6_t;
            r_o_contact <= n_dist <= i_thresh;
            r_o_s       <= r7_s;
            r_o_t       <= r7_t;
            r_o_dist    <= n_dist;
        end
    end

    assign o_valid   = r_o_valid;
    assign o_contact = r_o_contact;
    assign o_s       = r_o_s;
    assign o_t       = r_o_t;
    assign o_dist    = r_o_dist;

endmodule

`default_nettype wire

>>> rtl/core/segment_segment_contact_test.sv
`default_nettype none

// Segment-segment contact test. Each request carries the endpoints of two 3D
// segments P and Q as signed Q16.16 coordinates, and the block answers with
// the clamped closest-point parameters s on P and t on Q (unsigned Q1.16), the
// squared distance between the two closest points in units of 2^-32
// (saturated at all ones), and a contact flag that is set when that distance
// is at most the contact_threshold_sq register. The block accepts one request
// per clock while its internal queue has room and returns results in request
// order. Three chained 16-step restoring dividers for s0, t and s, each a
// 17-stage pipeline, make up most of the path from acceptance to the output
// register. A five-stage front end forms the difference vectors, picks the
// common scaling shifts and the dot products, and hands its work through a
// small queue to the back end, so a stall at the output does not immediately
// stop input acceptance. The threshold register sits at byte address 0 of the
// APB port. The user must write it only while the block is idle; nothing enforces it.
module segment_segment_contact_test import sscd_pkg::*; #(
    parameter int FIFO_DEPTH = FIFO_DEPTH_DEFAULT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,

    // Configuration port.
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,

    // Request channel.
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic signed [COORD_W-1:0]   i_p1_x,
    input  logic signed [COORD_W-1:0]   i_p1_y,
    input  logic signed [COORD_W-1:0]   i_p1_z,
    input  logic signed [COORD_W-1:0]   i_p2_x,
    input  logic signed [COORD_W-1:0]   i_p2_y,
    input  logic signed [COORD_W-1:0]   i_p2_z,
    input  logic signed [COORD_W-1:0]   i_q1_x,
    input  logic signed [COORD_W-1:0]   i_q1_y,
    input  logic signed [COORD_W-1:0]   i_q1_z,
    input  logic signed [COORD_W-1:0]   i_q2_x,
    input  logic signed [COORD_W-1:0]   i_q2_y,
    input  logic signed [COORD_W-1:0]   i_q2_z,

    // Result channel.
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic                        o_contact,
    output logic [PARAM_W-1:0]          o_param_on_p,
    output logic [PARAM_W-1:0]          o_param_on_q,
    output logic [DIST_W-1:0]           o_distance_sq
);

    // Word index of the threshold register on the configuration port.
    localparam logic REG_CONTACT_THRESHOLD_SQ = 1'b0;

    logic [DIST_W-1:0]                r_thresh;
    logic                             w_wr;
    logic [NUM_COORD-1:0][COORD_W-1:0] w_coord;

    logic  w_push;
    logic  w_full;
    logic  w_pop;
    logic  w_q_valid;
    t_fq   w_front_data;
    t_fq   w_q_data;

    // The port never inserts wait states.
    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready
                    && (paddr[2] == REG_CONTACT_THRESHOLD_SQ);
    assign prdata = (paddr[2] == REG_CONTACT_THRESHOLD_SQ) ? r_thresh : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= '0;
        end else if (w_wr) begin
            r_thresh <= pwdata;
        end
    end

    // Coordinates in the order p1, p2, q1, q2, each as x, y, z.
    assign w_coord[0]  = i_p1_x;
    assign w_coord[1]  = i_p1_y;
    assign w_coord[2]  = i_p1_z;
    assign w_coord[3]  = i_p2_x;
    assign w_coord[4]  = i_p2_y;
    assign w_coord[5]  = i_p2_z;
    assign w_coord[6]  = i_q1_x;
    assign w_coord[7]  = i_q1_y;
    assign w_coord[8]  = i_q1_z;
    assign w_coord[9]  = i_q2_x;
    assign w_coord[10] = i_q2_y;
    assign w_coord[11] = i_q2_z;

    sscd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_coord (w_coord),
        .o_push  (w_push),
        .i_full  (w_full),
        .o_data  (w_front_data)
    );

    sscd_fifo #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_front_data),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_data)
    );

    sscd_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_q_valid),
        .i_data    (w_q_data),
        .o_pop     (w_pop),
        .i_thresh  (r_thresh),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_contact (o_contact),
        .o_s       (o_param_on_p),
        .o_t       (o_param_on_q),
        .o_dist    (o_distance_sq)
    );

endmodule

`default_nettype wire

>>> verif/segment_segment_contact_test_tb.sv
`timescale 1ns / 1ps

module segment_segment_contact_test_tb;
    import sscd_pkg::*;

    // Register indexes on the configuration port.
    localparam int REG_THRESHOLD = 0;
    localparam int LATENCY       = 62;
    localparam int PIPE_FLUSH    = LATENCY + 20;

    typedef struct {
        logic signed [31:0] c [12];
    } t_seg_pair;

    typedef struct {
        logic        contact;
        logic [16:0] s;
        logic [16:0] t;
        logic [31:0] dist_sq;
    } t_contact_result;

    logic i_clk;
    logic i_rst_n;
    logic psel, penable, pwrite;
    logic [2:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;
    logic i_valid;
    logic o_ready;
    logic signed [31:0] coord [12];
    logic o_valid;
    logic i_ready;
    logic o_contact;
    logic [16:0] o_param_on_p;
    logic [16:0] o_param_on_q;
    logic [31:0] o_distance_sq;

    // Model copy of the threshold register.
    logic [31:0] threshold_sq;
    t_contact_result expected_q [$];
    int errors;
    int results_seen;
    int contacts_seen;
    int requests_sent;
    // Receiver control: idle bursts on or off, and a long hold-off request.
    bit rx_idle_on;
    int rx_hold_cycles;
    // Sender idle bursts on or off.
    bit tx_idle_on;

    segment_segment_contact_test dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_p1_x(coord[0]), .i_p1_y(coord[1]), .i_p1_z(coord[2]),
        .i_p2_x(coord[3]), .i_p2_y(coord[4]), .i_p2_z(coord[5]),
        .i_q1_x(coord[6]), .i_q1_y(coord[7]), .i_q1_z(coord[8]),
        .i_q2_x(coord[9]), .i_q2_y(coord[10]), .i_q2_z(coord[11]),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_contact(o_contact), .o_param_on_p(o_param_on_p),
        .o_param_on_q(o_param_on_q), .o_distance_sq(o_distance_sq)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Safety net against a hung handshake.
    initial begin
        #20ms;
        $display("** segment_segment_contact_test: FAILED **");
        $finish;
    end

    function automatic longint abs64(longint x);
        return x < 0 ? -x : x;
    endfunction

    // Scale the nine difference components down by one shared shift so that
    // every magnitude is below 2^lim; truncation is toward zero.
    function automatic void shrink_vectors(input longint src [9], input int lim,
                                           output longint dst [9]);
        longint biggest;
        int sh;
        biggest = 0;
        sh = 0;
        foreach (src[i]) if (abs64(src[i]) > biggest) biggest = abs64(src[i]);
        while (sh < 63 && (biggest >>> sh) >= (64'sd1 <<< lim)) sh++;
        foreach (src[i]) dst[i] = src[i] < 0 ? -(abs64(src[i]) >>> sh)
                                              : (abs64(src[i]) >>> sh);
    endfunction

    function automatic longint dot3(input longint v [9], int x, int y);
        return v[x]*v[y] + v[x+1]*v[y+1] + v[x+2]*v[y+2];
    endfunction

    // Clamped Q1.16 quotient num/den, floor, limited to 0..1.
    function automatic longint clamped_ratio(longint num, longint den);
        longint unsigned rem, dvs, q;
        if (den <= 0 || num <= 0) return 0;
        if (num >= den) return 65536;
        rem = num;
        dvs = den;
        q = 0;
        // Long division one bit at a time, so no wide product can overflow.
        for (int i = 0; i < 16; i++) begin
            rem = rem << 1;
            q = q << 1;
            if (rem >= dvs) begin
                rem = rem - dvs;
                q = q | 64'd1;
            end
        end
        return longint'(q);
    endfunction

    function automatic t_contact_result closest_points(t_seg_pair pr);
        longint vec [9], sc [9];
        longint a, b, c, d, e, den, s0, t, s, dd;
        longint unsigned m, q, dist_acc;
        bit sat;
        t_contact_result r;
        for (int i = 0; i < 3; i++) begin
            vec[i]   = longint'(pr.c[3+i]) - longint'(pr.c[i]);
            vec[3+i] = longint'(pr.c[9+i]) - longint'(pr.c[6+i]);
            vec[6+i] = longint'(pr.c[i]) - longint'(pr.c[6+i]);
        end
        shrink_vectors(vec, LIM_FIRST, sc);
        a = dot3(sc, 0, 0); b = dot3(sc, 0, 3); c = dot3(sc, 3, 3);
        d = dot3(sc, 0, 6); e = dot3(sc, 3, 6);
        den = a*c - b*b;
        // Parallel segments leave the first s estimate at zero.
        s0 = den > 0 ? clamped_ratio(b*e - c*d, den) : 0;
        shrink_vectors(vec, LIM_REST, sc);
        a = dot3(sc, 0, 0); b = dot3(sc, 0, 3); c = dot3(sc, 3, 3);
        d = dot3(sc, 0, 6); e = dot3(sc, 3, 6);
        t = clamped_ratio(b*s0 + e*65536, c*65536);
        s = clamped_ratio(b*t - d*65536, a*65536);
        dist_acc = 0;
        sat = 1'b0;
        for (int i = 0; i < 3; i++) begin
            dd = vec[6+i]*65536 + vec[i]*s - vec[3+i]*t;
            m = abs64(dd);
            q = (m + 64'd32768) >> 16;
            if (q >= 65536) sat = 1'b1;
            else dist_acc += q*q;
        end
        if (sat || dist_acc > 64'hFFFF_FFFF) dist_acc = 64'hFFFF_FFFF;
        r.dist_sq = dist_acc[31:0];
        r.contact = r.dist_sq <= threshold_sq;
        r.s = s[16:0];
        r.t = t[16:0];
        return r;
    endfunction

    task automatic write_threshold(logic [31:0] value);
        @(posedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= 3'(4*REG_THRESHOLD); pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        threshold_sq = value;
    endtask

    // Send one request, holding valid and payload until accepted. Valid stays
    // high after acceptance so the next request can follow at once; it drops
    // only for an idle burst or when the sequence drains.
    task automatic send_pair(t_seg_pair pr);
        if (tx_idle_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        foreach (coord[i]) coord[i] <= pr.c[i];
        expected_q.push_back(closest_points(pr));
        requests_sent++;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // Wait until every answer has arrived, then let the pipe drain.
    task automatic drain();
        i_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (PIPE_FLUSH) @(posedge i_clk);
    endtask

    function automatic logic signed [31:0] rand_coord(int mode);
        case (mode)
            0: return $urandom();
            1: return $signed($urandom_range(0, 2 * 65536 * 4)) - 65536 * 4;
            2: return $signed($urandom_range(0, 2000)) - 1000;
            default: return $signed($urandom_range(0, 2 * 65536 * 64)) - 65536 * 64;
        endcase
    endfunction

    // Random pair; most are near each other so contact and interior
    // parameters are common, the rest cover the full coordinate range.
    function automatic t_seg_pair random_pair();
        t_seg_pair pr;
        int mode;
        int kind;
        mode = $urandom_range(0, 9) < 2 ? 0 : $urandom_range(1, 3);
        foreach (pr.c[i]) pr.c[i] = rand_coord(mode);
        kind = $urandom_range(0, 9);
        if (kind == 0) for (int i = 0; i < 3; i++) pr.c[9+i] = pr.c[6+i];  // point Q
        if (kind == 1) for (int i = 0; i < 3; i++) pr.c[3+i] = pr.c[i];    // point P
        if (kind == 2) for (int i = 0; i < 3; i++)                         // parallel
            pr.c[9+i] = pr.c[6+i] + (pr.c[3+i] - pr.c[i]);
        return pr;
    endfunction

    function automatic t_seg_pair make_pair(logic signed [31:0] v [12]);
        t_seg_pair pr;
        pr.c = v;
        return pr;
    endfunction

    // Checker: compares each accepted result with the oldest expectation.
    always @(posedge i_clk) begin
        t_contact_result exp_r;
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            if (expected_q.size() == 0) begin
                $error("unexpected result with no request outstanding");
                errors++;
            end else begin
                exp_r = expected_q.pop_front();
                if (exp_r.contact) contacts_seen++;
                if (o_contact !== exp_r.contact) begin
                    $error("contact: expected %0d, got %0d", exp_r.contact, o_contact);
                    errors++;
                end
                if (o_param_on_p !== exp_r.s) begin
                    $error("param_on_p: expected %0d, got %0d", exp_r.s, o_param_on_p);
                    errors++;
                end
                if (o_param_on_q !== exp_r.t) begin
                    $error("param_on_q: expected %0d, got %0d", exp_r.t, o_param_on_q);
                    errors++;
                end
                if (o_distance_sq !== exp_r.dist_sq) begin
                    $error("distance_sq: expected %0d, got %0d", exp_r.dist_sq,
                           o_distance_sq);
                    errors++;
                end
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off when asked.
    initial begin
        i_ready = 1'b0;
        @(posedge i_clk);
        forever begin
            if (rx_hold_cycles > 0) begin
                i_ready <= 1'b0;
                repeat (rx_hold_cycles) @(posedge i_clk);
                rx_hold_cycles = 0;
            end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
            end else begin
                i_ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // Hand-picked geometry: crossing, parallel, degenerate and extreme cases.
    task automatic test_directed();
        logic signed [31:0] v [12];
        logic signed [31:0] one;
        one = 32'sh0001_0000;
        // Perpendicular crossing segments touching at their midpoints.
        v = '{-one, 0, 0, one, 0, 0, 0, -one, 0, 0, one, 0};
        send_pair(make_pair(v));
        // Skew lines offset by a quarter unit in z.
        v = '{-one, 0, 0, one, 0, 0, 0, -one, one/4, 0, one, one/4};
        send_pair(make_pair(v));
        // Parallel segments side by side.
        v = '{0, 0, 0, one, 0, 0, 0, one/2, 0, one, one/2, 0};
        send_pair(make_pair(v));
        // Both segments collapsed to points.
        v = '{5, 6, 7, 5, 6, 7, 100, -20, 3, 100, -20, 3};
        send_pair(make_pair(v));
        // Only Q collapsed to a point.
        v = '{0, 0, 0, one, one, 0, one/2, 0, 0, one/2, 0, 0};
        send_pair(make_pair(v));
        // Only P collapsed to a point.
        v = '{one/3, one/3, one/3, one/3, one/3, one/3, 0, 0, 0, one, 0, 0};
        send_pair(make_pair(v));
        // Clamping at both ends: segments apart along their common axis.
        v = '{0, 0, 0, one, 0, 0, 2*one, 0, 10, 3*one, 0, 10};
        send_pair(make_pair(v));
        v = '{2*one, 0, 0, 3*one, 0, 0, one, 1, 0, 0, 1, 0};
        send_pair(make_pair(v));
        // Far apart, saturated distance.
        v = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
              32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff,
              32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff};
        send_pair(make_pair(v));
        // Full-range opposite corners, every bit of each field toggles.
        v = '{32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000,
              32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff,
              32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff};
        send_pair(make_pair(v));
        v = '{-1, -1, -1, 0, 0, 0, -1, 0, -1, 0, -1, 0};
        send_pair(make_pair(v));
        // Very short Q next to a long P.
        v = '{-100*one, 0, 0, 100*one, 0, 0, 3, one, 0, 4, one, 0};
        send_pair(make_pair(v));
        // Distance just below one unit and just over.
        v = '{0, 0, 0, one, 0, 0, 0, one - 1, 0, one, one - 1, 0};
        send_pair(make_pair(v));
        v = '{0, 0, 0, one, 0, 0, 0, one, 1, one, one, 1};
        send_pair(make_pair(v));
        drain();
    endtask

    task automatic test_random(int count);
        repeat (count) send_pair(random_pair());
        drain();
    endtask

    // The receiver stops for a long while so the queue inside the block fills
    // and input acceptance stalls while requests keep coming.
    task automatic test_backpressure();
        rx_hold_cycles = 300;
        repeat (150) send_pair(random_pair());
        drain();
    endtask

    initial begin
        logic [31:0] thresholds [5];
        i_rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        i_valid = 1'b0;
        foreach (coord[i]) coord[i] = '0;
        threshold_sq = '0;
        errors = 0; results_seen = 0; contacts_seen = 0; requests_sent = 0;
        rx_idle_on = 1'b1; tx_idle_on = 1'b1; rx_hold_cycles = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Threshold at reset is zero: only exact touches count as contact.
        test_directed();
        thresholds = '{32'hFFFF_FFFF, 32'h0001_0000, 32'h4000_0000, 32'd1, 32'h0000_0000};
        write_threshold(32'hFFFF_FFFE);
        test_directed();
        foreach (thresholds[i]) begin
            write_threshold(thresholds[i]);
            test_random(160);
        end
        write_threshold(32'h0100_0000);
        test_backpressure();
        // Last stretch back to back on both sides.
        rx_idle_on = 1'b0; tx_idle_on = 1'b0;
        test_random(150);

        $display("Sent %0d requests under 8 threshold settings; checked %0d results, %0d in contact.",
                 requests_sent, results_seen, contacts_seen);
        if (errors == 0 && expected_q.size() == 0) begin
            $display("** segment_segment_contact_test: PASSED **");
        end else begin
            $display("** segment_segment_contact_test: FAILED **");
        end
        $finish;
    end

endmodule
